FILE: src/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and helpers of the FPGA configuration supervisor.
// ----------------------------------------------------------------------------
package fcs_pkg;

    // Field and counter widths
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 16;
    localparam int LIMIT_W = 16;
    localparam int CMP_W   = TICK_W + 1;

    // Stream and register port widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Register reset values
    localparam logic [LIMIT_W-1:0] LOAD_TIMEOUT_RST   = LIMIT_W'(5000);
    localparam logic [LIMIT_W-1:0] DETECT_TIMEOUT_RST = LIMIT_W'(100);
    localparam logic [LIMIT_W-1:0] ERROR_HOLD_RST     = LIMIT_W'(3000);
    localparam logic [LIMIT_W-1:0] POLL_INTERVAL_RST  = LIMIT_W'(500);

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_LOAD_TIMEOUT   = 3'd0;
    localparam logic [2:0] REG_DETECT_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_ERROR_HOLD     = 3'd2;
    localparam logic [2:0] REG_POLL_INTERVAL  = 3'd3;
    localparam logic [2:0] REG_DONE_FITTED    = 3'd4;

    // Supervisor state codes as seen on the result channel
    localparam logic [2:0] CODE_STANDBY = 3'd0;
    localparam logic [2:0] CODE_LOAD    = 3'd1;
    localparam logic [2:0] CODE_RESET   = 3'd2;
    localparam logic [2:0] CODE_RUN     = 3'd3;
    localparam logic [2:0] CODE_PAUSE   = 3'd4;
    localparam logic [2:0] CODE_ERROR   = 3'd5;

    // Device status codes
    localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
    localparam logic [1:0] STATUS_NORMAL  = 2'd1;
    localparam logic [1:0] STATUS_FAIL    = 2'd2;

    // Supervisor state, one-hot
    typedef enum logic [5:0] {
        ST_STANDBY = 6'b000001,
        ST_LOAD    = 6'b000010,
        ST_RESET   = 6'b000100,
        ST_RUN     = 6'b001000,
        ST_PAUSE   = 6'b010000,
        ST_ERROR   = 6'b100000
    } fcs_state_t;

    // One poll
    typedef struct packed {
        logic [TICK_W-1:0] now_tick;
        logic              init_b_pin;
        logic              done_pin;
        logic              power_enabled;
        logic              core_power_good;
        logic              clock_ready;
        logic              detect_ok;
        logic              detect_normal;
        logic              poll_ok;
        logic              poll_had_errors;
    } fcs_item_t;

    // Configuration register values
    typedef struct packed {
        logic [LIMIT_W-1:0] load_timeout_ticks;
        logic [LIMIT_W-1:0] detect_timeout_ticks;
        logic [LIMIT_W-1:0] error_hold_ticks;
        logic [LIMIT_W-1:0] poll_interval_ticks;
        logic               done_pin_fitted;
    } fcs_cfg_t;

    // Supervisor context carried from poll to poll
    typedef struct packed {
        fcs_state_t         state;
        logic [TICK_W-1:0]  entry_tick;
        logic [TICK_W-1:0]  load_start_tick;
        logic               prev_done_known;
        logic               prev_done;
        logic               timeout_flag;
        logic [COUNT_W-1:0] detect_fail_count;
        logic [COUNT_W-1:0] error_count;
        logic [1:0]         status;
        logic               warning;
        logic               iface;
    } fcs_ctx_t;

    // One result
    typedef struct packed {
        logic [2:0]         fsm_state;
        logic [1:0]         health_code;
        logic               bus_warning;
        logic               interface_enable;
        logic               load_timed_out;
        logic [COUNT_W-1:0] detect_fail_total;
        logic [COUNT_W-1:0] error_total;
        logic               detect_request;
        logic               poll_request;
        logic [TICK_W-1:0]  load_ticks;
    } fcs_result_t;

    // Map the one-hot state onto its external code
    function automatic logic [2:0] state_code(input fcs_state_t st);
        logic [2:0] code;
        unique case (st)
            ST_STANDBY: code = CODE_STANDBY;
            ST_LOAD:    code = CODE_LOAD;
            ST_RESET:   code = CODE_RESET;
            ST_RUN:     code = CODE_RUN;
            ST_PAUSE:   code = CODE_PAUSE;
            ST_ERROR:   code = CODE_ERROR;
            default:    code = CODE_STANDBY;
        endcase
        return code;
    endfunction

    // Saturating counter increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (&c) ? c : c + COUNT_W'(1);
    endfunction

endpackage

FILE: src/fcs_apb_regs.sv
// ----------------------------------------------------------------------------
// fcs_apb_regs
// APB register file holding the supervisor timeouts and the done-pin option.
// ----------------------------------------------------------------------------
module fcs_apb_regs import fcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output fcs_cfg_t           cfg_o
);

    fcs_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_o   = cfg_reg;

    // Write the addressed register on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.load_timeout_ticks   <= LOAD_TIMEOUT_RST;
            cfg_reg.detect_timeout_ticks <= DETECT_TIMEOUT_RST;
            cfg_reg.error_hold_ticks     <= ERROR_HOLD_RST;
            cfg_reg.poll_interval_ticks  <= POLL_INTERVAL_RST;
            cfg_reg.done_pin_fitted      <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LOAD_TIMEOUT:   cfg_reg.load_timeout_ticks   <= pwdata[LIMIT_W-1:0];
                REG_DETECT_TIMEOUT: cfg_reg.detect_timeout_ticks <= pwdata[LIMIT_W-1:0];
                REG_ERROR_HOLD:     cfg_reg.error_hold_ticks     <= pwdata[LIMIT_W-1:0];
                REG_POLL_INTERVAL:  cfg_reg.poll_interval_ticks  <= pwdata[LIMIT_W-1:0];
                REG_DONE_FITTED:    cfg_reg.done_pin_fitted      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero beyond the list
    always_comb begin
        unique case (reg_idx)
            REG_LOAD_TIMEOUT:   prdata = PDATA_W'(cfg_reg.load_timeout_ticks);
            REG_DETECT_TIMEOUT: prdata = PDATA_W'(cfg_reg.detect_timeout_ticks);
            REG_ERROR_HOLD:     prdata = PDATA_W'(cfg_reg.error_hold_ticks);
            REG_POLL_INTERVAL:  prdata = PDATA_W'(cfg_reg.poll_interval_ticks);
            REG_DONE_FITTED:    prdata = PDATA_W'(cfg_reg.done_pin_fitted);
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: src/fcs_step.sv
// ----------------------------------------------------------------------------
// fcs_step
// Decision logic for one poll: next supervisor context and the result item.
// ----------------------------------------------------------------------------
module fcs_step import fcs_pkg::*; (
    input  fcs_item_t   item_i,
    input  fcs_ctx_t    ctx_i,
    input  fcs_cfg_t    cfg_i,
    output fcs_ctx_t    ctx_o,
    output fcs_result_t res_o
);

    logic              fitted;
    logic              initb;
    logic              donep;
    logic              power_present;
    logic              enable;
    logic              done;
    logic [TICK_W-1:0] elapsed;
    logic [CMP_W-1:0]  elapsed_x;
    logic [CMP_W-1:0]  detect_limit;
    logic              det_req;
    logic              poll_req;
    logic [TICK_W-1:0] lticks;
    fcs_ctx_t          nx;

    // Qualify the pins
    assign fitted        = cfg_i.done_pin_fitted;
    assign initb         = fitted ? item_i.init_b_pin : 1'b1;
    assign donep         = fitted ? item_i.done_pin : 1'b1;
    assign power_present = item_i.power_enabled && item_i.core_power_good;
    assign enable        = item_i.clock_ready && power_present && initb;
    assign done          = power_present && donep;

    // Time in the current state, wrapping
    assign elapsed      = item_i.now_tick - ctx_i.entry_tick;
    assign elapsed_x    = CMP_W'(elapsed);
    assign detect_limit = CMP_W'(cfg_i.detect_timeout_ticks)
                        + (fitted ? CMP_W'(0) : CMP_W'(cfg_i.load_timeout_ticks));

    always_comb begin
        nx       = ctx_i;
        det_req  = 1'b0;
        poll_req = 1'b0;
        lticks   = '0;

        // Follow edges of done for the interface enable
        if (!ctx_i.prev_done_known || (ctx_i.prev_done != done)) begin
            nx.prev_done_known = 1'b1;
            nx.prev_done       = done;
            nx.iface           = done;
        end

        unique case (ctx_i.state)
            ST_STANDBY: begin
                nx.status            = STATUS_UNKNOWN;
                nx.detect_fail_count = '0;
                nx.error_count       = '0;
                nx.timeout_flag      = 1'b0;
                if (enable) begin
                    nx.state           = ST_LOAD;
                    nx.load_start_tick = item_i.now_tick;
                end
            end
            ST_LOAD: begin
                if (!enable) begin
                    nx.state = ST_STANDBY;
                end else if (done) begin
                    lticks   = item_i.now_tick - ctx_i.load_start_tick;
                    nx.state = ST_RESET;
                end else if (elapsed_x > CMP_W'(cfg_i.load_timeout_ticks)) begin
                    nx.timeout_flag = 1'b1;
                end
            end
            ST_RESET: begin
                if (!power_present) begin
                    nx.state = ST_STANDBY;
                end else if (fitted && !done) begin
                    nx.timeout_flag = 1'b0;
                    nx.state        = ST_LOAD;
                end else begin
                    nx.status = STATUS_UNKNOWN;
                    det_req   = 1'b1;
                    if (!item_i.detect_ok) begin
                        nx.state = ST_ERROR;
                    end else if (item_i.detect_normal) begin
                        nx.status = STATUS_NORMAL;
                        nx.state  = ST_RUN;
                    end else if (elapsed_x > detect_limit) begin
                        nx.detect_fail_count = sat_inc(ctx_i.detect_fail_count);
                        nx.state             = ST_ERROR;
                    end
                end
            end
            ST_RUN: begin
                if (!power_present || !done) begin
                    nx.state = ST_STANDBY;
                end else begin
                    poll_req = 1'b1;
                    if (item_i.poll_ok) begin
                        nx.warning = item_i.poll_had_errors;
                        nx.state   = ST_PAUSE;
                    end else begin
                        nx.error_count = sat_inc(ctx_i.error_count);
                        nx.state       = ST_ERROR;
                    end
                end
            end
            ST_PAUSE: begin
                // Poll delay wins over loss of done
                if (elapsed_x > CMP_W'(cfg_i.poll_interval_ticks)) begin
                    nx.state = ST_RUN;
                end else if (!done) begin
                    nx.state = ST_STANDBY;
                end
            end
            ST_ERROR: begin
                nx.error_count = sat_inc(ctx_i.error_count);
                nx.status      = STATUS_FAIL;
                if (elapsed_x > CMP_W'(cfg_i.error_hold_ticks)) begin
                    nx.state = ST_RESET;
                end
            end
            default: ;
        endcase

        // Restart the state timer on any move
        if (nx.state != ctx_i.state) begin
            nx.entry_tick = item_i.now_tick;
        end
    end

    assign ctx_o = nx;

    // Assemble the result
    assign res_o.fsm_state         = state_code(nx.state);
    assign res_o.health_code       = nx.status;
    assign res_o.bus_warning       = nx.warning;
    assign res_o.interface_enable  = nx.iface;
    assign res_o.load_timed_out    = nx.timeout_flag;
    assign res_o.detect_fail_total = nx.detect_fail_count;
    assign res_o.error_total       = nx.error_count;
    assign res_o.detect_request    = det_req;
    assign res_o.poll_request      = poll_req;
    assign res_o.load_ticks        = lticks;

endmodule

FILE: src/fpga_config_supervisor_unit.sv
// ----------------------------------------------------------------------------
// fpga_config_supervisor_unit
// Poll-driven FPGA configuration supervisor with APB configuration.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports             Carries
//  s_        in         s_tvalid/tready   one poll per transfer
//  m_        out        m_tvalid/tready   one result per poll
//  APB       in/out     psel..pready      five configuration registers
//
//  Each poll passes through the poll register and then the result register;
//  one poll per cycle is sustained while m_ does not stall, set by the single
//  step of decision logic between the poll register and the result register.
//  Reset is synchronous and clears the supervisor to standby and the
//  registers to their defaults.
//  A stall on m_ holds the result; s_tready drops only when both the poll
//  register and the result register are full.
// ----------------------------------------------------------------------------
module fpga_config_supervisor_unit import fcs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // poll: [31:0] now_tick, [32] init_b_pin, [33] done_pin, [34] power_enabled,
    // [35] core_power_good, [36] clock_ready, [37] detect_ok, [38] detect_normal,
    // [39] poll_ok, [40] poll_had_errors, [47:41] zero
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // result: [2:0] fsm_state, [4:3] health_code, [5] bus_warning,
    // [6] interface_enable, [7] load_timed_out, [23:8] detect_fail_total,
    // [39:24] error_total, [40] detect_request, [41] poll_request,
    // [73:42] load_ticks, [79:74] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int ITEM_W = $bits(fcs_item_t);
    localparam int RES_W  = TICK_W + 2 * COUNT_W + 10;

    fcs_cfg_t    cfg;
    fcs_item_t   item_reg;
    logic        in_valid_reg;
    fcs_ctx_t    ctx_reg;
    fcs_ctx_t    ctx_next;
    fcs_result_t res_next;
    fcs_result_t res_reg;
    logic        out_valid_reg;
    logic        out_adv;
    logic        step_en;
    fcs_item_t   s_item;

    fcs_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    fcs_step u_step (
        .item_i (item_reg),
        .ctx_i  (ctx_reg),
        .cfg_i  (cfg),
        .ctx_o  (ctx_next),
        .res_o  (res_next)
    );

    // Unpack the poll
    assign s_item.now_tick        = s_tdata[TICK_W-1:0];
    assign s_item.init_b_pin      = s_tdata[TICK_W];
    assign s_item.done_pin        = s_tdata[TICK_W+1];
    assign s_item.power_enabled   = s_tdata[TICK_W+2];
    assign s_item.core_power_good = s_tdata[TICK_W+3];
    assign s_item.clock_ready     = s_tdata[TICK_W+4];
    assign s_item.detect_ok       = s_tdata[TICK_W+5];
    assign s_item.detect_normal   = s_tdata[TICK_W+6];
    assign s_item.poll_ok         = s_tdata[TICK_W+7];
    assign s_item.poll_had_errors = s_tdata[ITEM_W-1];

    // Flow control: advance the result stage when empty or drained
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign step_en  = in_valid_reg && out_adv;

    // Poll register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    // Supervisor context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.state             <= ST_STANDBY;
            ctx_reg.entry_tick        <= '0;
            ctx_reg.load_start_tick   <= '0;
            ctx_reg.prev_done_known   <= 1'b0;
            ctx_reg.prev_done         <= 1'b0;
            ctx_reg.timeout_flag      <= 1'b0;
            ctx_reg.detect_fail_count <= '0;
            ctx_reg.error_count       <= '0;
            ctx_reg.status            <= STATUS_UNKNOWN;
            ctx_reg.warning           <= 1'b0;
            ctx_reg.iface             <= 1'b0;
        end else if (step_en) begin
            ctx_reg <= ctx_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= res_next;
        end
    end

    // Pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0),
                       res_reg.load_ticks,
                       res_reg.poll_request,
                       res_reg.detect_request,
                       res_reg.error_total,
                       res_reg.detect_fail_total,
                       res_reg.load_timed_out,
                       res_reg.interface_enable,
                       res_reg.bus_warning,
                       res_reg.health_code,
                       res_reg.fsm_state};

endmodule

FILE: src/fcs_checker.sv
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks of the supervisor result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fcs_checker import fcs_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [2:0]        st;
    logic              det_req;
    logic              poll_req;
    logic [TICK_W-1:0] lticks;

    assign st       = m_tdata[2:0];
    assign det_req  = m_tdata[40];
    assign poll_req = m_tdata[41];
    assign lticks   = m_tdata[TICK_W+41:42];

    // Hold a stalled transfer
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // A detect probe only ends in reset, run or error
    a_detect_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && det_req) |->
            (st == CODE_RESET || st == CODE_RUN || st == CODE_ERROR))
        else $error("detect request with wrong next state");

    // A health poll only ends in pause or error
    a_poll_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && poll_req) |-> (st == CODE_PAUSE || st == CODE_ERROR))
        else $error("poll request with wrong next state");

    // Load time is reported only on the move into reset
    a_load_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && lticks != '0) |-> (st == CODE_RESET && !det_req && !poll_req))
        else $error("load ticks outside load completion");

endmodule

bind fpga_config_supervisor_unit fcs_checker u_fcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
